FILE: hw/rtl/mphf_pkg.sv
// shared constants and types for the masked pixel hole fill block
// no dependencies; imported by every module of the block
package mphf_pkg;

  localparam int DEF_MAX_WIDTH     = 64;
  localparam int DEF_MAX_HEIGHT    = 48;
  localparam int DEF_WINDOW_FRAMES = 5;
  localparam int DEF_FRAME_SLOTS   = 6;
  localparam int DEF_QUEUE_DEPTH   = 4;

  localparam int CHAN_W       = 8;
  localparam int WIDTH_REG_W  = 7;
  localparam int HEIGHT_REG_W = 6;
  localparam int CFG_DATA_W   = 7;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 7'd64;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 6'd48;

  // stored pixel: colour plus presence flag
  typedef struct packed {
    logic              present;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

endpackage

FILE: hw/rtl/masked_pixel_hole_fill_top.sv
// top level of the masked pixel hole fill block
// depends on mphf_pkg, mphf_front, mphf_queue, mphf_back
//
// steps per item: an item before the delayed frame exists goes straight to the output; a present
//   centre pixel is read and output; a null centre scans the window, then divides unless it is empty
// work per item: the back part finishes one item before it takes the next; the single read port of the frame ring
//   takes one window pixel per cycle over 5 frames x 3x3 and the divider a bit a cycle
// reset: synchronous; counters and config registers reset, then a clearing pass zeroes all
//   FRAME_SLOTS*MAX_WIDTH*MAX_HEIGHT ring entries (18432), no item taken
module masked_pixel_hole_fill_top import mphf_pkg::*; #(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int WINDOW_FRAMES = DEF_WINDOW_FRAMES,
  parameter int FRAME_SLOTS   = DEF_FRAME_SLOTS,
  parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // config: index 0 frame_width, index 1 frame_height
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [3*CHAN_W-1:0]   s_axis_tdata,   // red, green, blue
  input  logic [0:0]            s_axis_tuser,   // pixel_present
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [3*CHAN_W-1:0]   m_axis_tdata,   // out_red, out_green, out_blue
  output logic [1:0]            m_axis_tuser    // out_present, out_ready
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SLOT_W = $clog2(FRAME_SLOTS);
  localparam int WU_W   = $clog2(MAX_WIDTH + 1);
  localparam int HU_W   = $clog2(MAX_HEIGHT + 1);
  localparam int PIX_W  = $bits(pixel_t);
  // queue item: pixel, column, row, ring slot, ready tag
  localparam int Q_W    = PIX_W + COL_W + ROW_W + SLOT_W + 1;

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  logic [Q_W-1:0]    q_in;
  logic [Q_W-1:0]    q_head;
  logic              clear_busy;
  logic [COL_W-1:0]  f_col;
  logic [ROW_W-1:0]  f_row;
  logic [SLOT_W-1:0] f_slot;
  logic              f_rdy;
  logic [WU_W-1:0]   w_use;
  logic [HU_W-1:0]   h_use;
  pixel_t            in_pix;
  pixel_t            head_pix;
  logic [COL_W-1:0]  head_col;
  logic [ROW_W-1:0]  head_row;
  logic [SLOT_W-1:0] head_slot;
  logic              head_rdy;

  assign in_pix.red     = s_axis_tdata[CHAN_W-1:0];
  assign in_pix.green   = s_axis_tdata[2*CHAN_W-1:CHAN_W];
  assign in_pix.blue    = s_axis_tdata[3*CHAN_W-1:2*CHAN_W];
  assign in_pix.present = s_axis_tuser[0];

  assign q_in = {f_rdy, f_slot, f_row, f_col, in_pix};
  assign {head_rdy, head_slot, head_row, head_col, head_pix} = q_head;

  // front: counts raster position and tags each item with its ring slot
  mphf_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .WINDOW_FRAMES(WINDOW_FRAMES), .FRAME_SLOTS(FRAME_SLOTS),
    .COL_W(COL_W), .ROW_W(ROW_W), .SLOT_W(SLOT_W), .WU_W(WU_W), .HU_W(HU_W)
  ) u_front (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .q_full(q_full), .clear_busy(clear_busy), .push(q_push),
    .item_col(f_col), .item_row(f_row), .item_slot(f_slot), .item_rdy(f_rdy),
    .w_use(w_use), .h_use(h_use)
  );

  // decouples intake from the multi-cycle window work
  mphf_queue #(
    .WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .head_valid(q_valid), .head_data(q_head)
  );

  // back: reads the ring, fills holes, writes the new pixel, holds the result
  mphf_back #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .WINDOW_FRAMES(WINDOW_FRAMES), .FRAME_SLOTS(FRAME_SLOTS),
    .COL_W(COL_W), .ROW_W(ROW_W), .SLOT_W(SLOT_W), .WU_W(WU_W), .HU_W(HU_W)
  ) u_back (
    .clk(clk), .rst(rst), .clear_busy(clear_busy),
    .q_valid(q_valid), .q_pop(q_pop),
    .item_pix(head_pix), .item_col(head_col), .item_row(head_row),
    .item_slot(head_slot), .item_rdy(head_rdy),
    .w_use(w_use), .h_use(h_use),
    .out_valid(m_axis_tvalid), .out_take(m_axis_tready),
    .out_data(m_axis_tdata), .out_user(m_axis_tuser)
  );

endmodule

FILE: hw/rtl/mphf_queue.sv
// small fifo between the front and back parts of the hole fill block
// depends on mphf_pkg
module mphf_queue import mphf_pkg::*; #(
  parameter int WIDTH = 32,
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (32'(count) == DEPTH);
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/mphf_front.sv
// front part: config registers, raster position counters, ring slot and
// readiness tagging of each accepted item; depends on mphf_pkg
module mphf_front import mphf_pkg::*; #(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int WINDOW_FRAMES = DEF_WINDOW_FRAMES,
  parameter int FRAME_SLOTS   = DEF_FRAME_SLOTS,
  parameter int COL_W         = $clog2(MAX_WIDTH),
  parameter int ROW_W         = $clog2(MAX_HEIGHT),
  parameter int SLOT_W        = $clog2(FRAME_SLOTS),
  parameter int WU_W          = $clog2(MAX_WIDTH + 1),
  parameter int HU_W          = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  q_full,
  input  logic                  clear_busy,
  output logic                  push,
  output logic [COL_W-1:0]      item_col,
  output logic [ROW_W-1:0]      item_row,
  output logic [SLOT_W-1:0]     item_slot,
  output logic                  item_rdy,
  output logic [WU_W-1:0]       w_use,
  output logic [HU_W-1:0]       h_use
);

  localparam int WIN_BEFORE = (WINDOW_FRAMES - 1) / 2;
  localparam int DELAY      = WINDOW_FRAMES - 1 - WIN_BEFORE + 1;
  localparam int FS_W       = $clog2(DELAY + 1);

  logic [WIDTH_REG_W-1:0]  frame_width;
  logic [HEIGHT_REG_W-1:0] frame_height;
  logic [COL_W-1:0]        column_count;
  logic [ROW_W-1:0]        row_count;
  logic [SLOT_W-1:0]       write_slot;
  logic [FS_W-1:0]         frames_seen;
  logic [COL_W:0]          col_inc;
  logic [ROW_W:0]          row_inc;

  assign in_ready  = !q_full && !clear_busy;
  assign push      = in_valid && in_ready;
  assign item_col  = column_count;
  assign item_row  = row_count;
  assign item_slot = write_slot;
  assign item_rdy  = (32'(frames_seen) == DELAY);
  assign col_inc   = {1'b0, column_count} + 1'b1;
  assign row_inc   = {1'b0, row_count} + 1'b1;

  // out of range sizes clamp to one and to the maximum
  always_comb begin
    if (frame_width == '0) begin
      w_use = WU_W'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_use = WU_W'(MAX_WIDTH);
    end else begin
      w_use = WU_W'(frame_width);
    end
    if (frame_height == '0) begin
      h_use = HU_W'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_use = HU_W'(MAX_HEIGHT);
    end else begin
      h_use = HU_W'(frame_height);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_IDX_WIDTH) begin
        frame_width <= cfg_data;
      end else if (cfg_index == CFG_IDX_HEIGHT) begin
        frame_height <= cfg_data[HEIGHT_REG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      write_slot   <= '0;
      frames_seen  <= '0;
    end else if (push) begin
      if (32'(col_inc) >= 32'(w_use)) begin
        column_count <= '0;
        if (32'(row_inc) >= 32'(h_use)) begin
          row_count  <= '0;
          write_slot <= (32'(write_slot) == FRAME_SLOTS - 1) ? '0 : write_slot + 1'b1;
          if (32'(frames_seen) < DELAY) begin
            frames_seen <= frames_seen + 1'b1;
          end
        end else begin
          row_count <= row_inc[ROW_W-1:0];
        end
      end else begin
        column_count <= col_inc[COL_W-1:0];
      end
    end
  end

endmodule

FILE: hw/rtl/mphf_back.sv
// back part: frame ring memory, window scan, per-channel divider and
// output register; depends on mphf_pkg
module mphf_back import mphf_pkg::*; #(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int WINDOW_FRAMES = DEF_WINDOW_FRAMES,
  parameter int FRAME_SLOTS   = DEF_FRAME_SLOTS,
  parameter int COL_W         = $clog2(MAX_WIDTH),
  parameter int ROW_W         = $clog2(MAX_HEIGHT),
  parameter int SLOT_W        = $clog2(FRAME_SLOTS),
  parameter int WU_W          = $clog2(MAX_WIDTH + 1),
  parameter int HU_W          = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  output logic                 clear_busy,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  pixel_t               item_pix,
  input  logic [COL_W-1:0]     item_col,
  input  logic [ROW_W-1:0]     item_row,
  input  logic [SLOT_W-1:0]    item_slot,
  input  logic                 item_rdy,
  input  logic [WU_W-1:0]      w_use,
  input  logic [HU_W-1:0]      h_use,
  output logic                 out_valid,
  input  logic                 out_take,
  output logic [3*CHAN_W-1:0]  out_data,
  output logic [1:0]           out_user
);

  localparam int WIN_BEFORE = (WINDOW_FRAMES - 1) / 2;
  localparam int DELAY      = WINDOW_FRAMES - 1 - WIN_BEFORE + 1;
  localparam int FIRST_BACK = DELAY + WIN_BEFORE;
  localparam int FIRST_OFF  = (FRAME_SLOTS - (FIRST_BACK % FRAME_SLOTS)) % FRAME_SLOTS;
  localparam int CENTER_OFF = (FRAME_SLOTS - (DELAY % FRAME_SLOTS)) % FRAME_SLOTS;
  localparam int SLOT_SIZE  = MAX_WIDTH * MAX_HEIGHT;
  localparam int DEPTH      = FRAME_SLOTS * SLOT_SIZE;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int WIN_MAX    = WINDOW_FRAMES * 9;
  localparam int CNT_W      = $clog2(WIN_MAX + 1);
  localparam int SUM_W      = CHAN_W + CNT_W;
  localparam int STEP_W     = $clog2(SUM_W + 1);
  localparam int T_W        = $clog2(WINDOW_FRAMES + 1);

  typedef enum logic [7:0] {
    B_CLEAR = 8'b0000_0001,
    B_IDLE  = 8'b0000_0010,
    B_CHECK = 8'b0000_0100,
    B_SCAN  = 8'b0000_1000,
    B_DRAIN = 8'b0001_0000,
    B_LOAD  = 8'b0010_0000,
    B_DIV   = 8'b0100_0000,
    B_OUT   = 8'b1000_0000
  } back_state_t;

  back_state_t       state;
  pixel_t            ring [DEPTH];
  pixel_t            rd_data;
  pixel_t            res_pix;
  logic              res_rdy;
  logic              use_div;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] item_addr;
  logic              mem_we;
  pixel_t            mem_wdata;
  logic              fire;

  logic [T_W-1:0]    scan_t;
  logic [1:0]        scan_dy;
  logic [1:0]        scan_dx;
  logic [SLOT_W-1:0] scan_slot;
  logic [ROW_W:0]    yy;
  logic [COL_W:0]    xx;
  logic              in_win;
  logic              scan_last;
  logic              acc_en;
  logic [SLOT_W:0]   center_sum;
  logic [SLOT_W-1:0] center_slot;
  logic [SLOT_W:0]   first_sum;
  logic [SLOT_W-1:0] first_slot;

  logic [SUM_W-1:0]  acc [3];
  logic [CNT_W-1:0]  acc_cnt;
  logic [CHAN_W-1:0] rd_ch [3];
  logic [SUM_W-1:0]  quo [3];
  logic [CNT_W-1:0]  rem [3];
  logic [CNT_W:0]    trial [3];
  logic              ge [3];
  logic [STEP_W-1:0] div_step;

  // ring slot arithmetic, offsets stay below the slot count
  always_comb begin
    center_sum = {1'b0, item_slot} + (SLOT_W+1)'(CENTER_OFF);
    if (32'(center_sum) >= FRAME_SLOTS) begin
      center_sum = center_sum - (SLOT_W+1)'(FRAME_SLOTS);
    end
    center_slot = center_sum[SLOT_W-1:0];
    first_sum = {1'b0, item_slot} + (SLOT_W+1)'(FIRST_OFF);
    if (32'(first_sum) >= FRAME_SLOTS) begin
      first_sum = first_sum - (SLOT_W+1)'(FRAME_SLOTS);
    end
    first_slot = first_sum[SLOT_W-1:0];
  end

  // neighbour position; a wrap below zero lands far beyond the size in use
  assign yy        = {1'b0, item_row} + (ROW_W+1)'(scan_dy) - (ROW_W+1)'(1);
  assign xx        = {1'b0, item_col} + (COL_W+1)'(scan_dx) - (COL_W+1)'(1);
  assign in_win    = (32'(yy) < 32'(h_use)) && (32'(xx) < 32'(w_use));
  assign scan_last = (32'(scan_t) == WINDOW_FRAMES - 1) && (scan_dy == 2'd2)
                     && (scan_dx == 2'd2);

  assign item_addr = ADDR_W'(item_slot) * ADDR_W'(SLOT_SIZE)
                   + ADDR_W'(item_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(item_col);

  always_comb begin
    if (state == B_SCAN) begin
      rd_addr = ADDR_W'(scan_slot) * ADDR_W'(SLOT_SIZE)
              + ADDR_W'(yy[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xx[COL_W-1:0]);
    end else begin
      rd_addr = ADDR_W'(center_slot) * ADDR_W'(SLOT_SIZE)
              + ADDR_W'(item_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(item_col);
    end
  end

  assign fire       = (state == B_OUT) && (!out_valid || out_take);
  assign q_pop      = fire;
  assign clear_busy = (state == B_CLEAR);
  assign mem_we     = (state == B_CLEAR) || fire;
  assign wr_addr    = (state == B_CLEAR) ? clr_addr : item_addr;
  assign mem_wdata  = (state == B_CLEAR) ? pixel_t'('0) : item_pix;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wr_addr] <= mem_wdata;
    end
    rd_data <= ring[rd_addr];
  end

  assign rd_ch[0] = rd_data.red;
  assign rd_ch[1] = rd_data.green;
  assign rd_ch[2] = rd_data.blue;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem[c], quo[c][SUM_W-1]};
      ge[c]    = (trial[c] >= {1'b0, acc_cnt});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      acc_en    <= 1'b0;
    end else begin
      acc_en <= (state == B_SCAN) && in_win;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == DEPTH - 1) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_valid) begin
            res_rdy <= item_rdy;
            use_div <= 1'b0;
            res_pix <= '0;
            state   <= item_rdy ? B_CHECK : B_OUT;
          end
        end
        B_CHECK: begin
          if (rd_data.present) begin
            res_pix <= rd_data;
            state   <= B_OUT;
          end else begin
            scan_t    <= '0;
            scan_dy   <= '0;
            scan_dx   <= '0;
            scan_slot <= first_slot;
            state     <= B_SCAN;
          end
        end
        B_SCAN: begin
          if (scan_dx == 2'd2) begin
            scan_dx <= '0;
            if (scan_dy == 2'd2) begin
              scan_dy   <= '0;
              scan_t    <= scan_t + 1'b1;
              scan_slot <= (32'(scan_slot) == FRAME_SLOTS - 1) ? '0 : scan_slot + 1'b1;
            end else begin
              scan_dy <= scan_dy + 1'b1;
            end
          end else begin
            scan_dx <= scan_dx + 1'b1;
          end
          if (scan_last) begin
            state <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          state <= B_LOAD;
        end
        B_LOAD: begin
          if (acc_cnt == '0) begin
            state <= B_OUT;
          end else begin
            div_step <= '0;
            use_div  <= 1'b1;
            state    <= B_DIV;
          end
        end
        B_DIV: begin
          div_step <= div_step + 1'b1;
          if (32'(div_step) == SUM_W - 1) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (fire) begin
            out_data <= use_div ? {quo[2][CHAN_W-1:0], quo[1][CHAN_W-1:0],
                                   quo[0][CHAN_W-1:0]}
                                : {res_pix.blue, res_pix.green, res_pix.red};
            out_user <= {res_rdy, use_div | res_pix.present};
            state    <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // window sums, then a restoring divide of all three channels together
  always_ff @(posedge clk) begin
    if (state == B_CHECK) begin
      acc_cnt <= '0;
      for (int c = 0; c < 3; c++) begin
        acc[c] <= '0;
      end
    end else if (acc_en && rd_data.present) begin
      acc_cnt <= acc_cnt + 1'b1;
      for (int c = 0; c < 3; c++) begin
        acc[c] <= acc[c] + SUM_W'(rd_ch[c]);
      end
    end
    if (state == B_LOAD) begin
      for (int c = 0; c < 3; c++) begin
        quo[c] <= acc[c];
        rem[c] <= '0;
      end
    end else if (state == B_DIV) begin
      for (int c = 0; c < 3; c++) begin
        rem[c] <= ge[c] ? CNT_W'(trial[c] - {1'b0, acc_cnt}) : CNT_W'(trial[c]);
        quo[c] <= {quo[c][SUM_W-2:0], ge[c]};
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == B_LOAD |-> 32'(acc_cnt) <= WIN_MAX)
    else $error("window count above window size");

  a_not_ready_null: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_user[1] |-> !out_user[0])
    else $error("present result before delayed frame exists");

  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_user[0] |-> out_data == '0)
    else $error("null result carries colour");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == B_DIV |=> state == B_DIV || state == B_OUT)
    else $error("divider left early");

endmodule
